// ===== src/assert_macros.svh =====
// Assertion macros for the IR pulse-distance transmitter RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clk edge outside reset.
`define IRPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication: cause now, effect next edge.
`define IRPD_ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

// ===== src/irpd_pkg.sv =====
// Package for the IR pulse-distance transmitter: types, segment lengths,
// counter widths. Depends on nothing.
package irpd_pkg;

    localparam int TICK_COUNT_WIDTH = 16;
    localparam int UNIT_TICKS_W     = 16;
    localparam int ADDR_W           = 8;
    localparam int CMD_W            = 8;
    localparam int COUNT_W          = 8;
    localparam int UNITS_W          = 5;
    localparam int BIT_IDX_W        = 5;
    localparam int CFG_DATA_W       = 16;
    localparam int CMP_W = (TICK_COUNT_WIDTH + 1 > UNIT_TICKS_W + 1) ?
                           TICK_COUNT_WIDTH + 1 : UNIT_TICKS_W + 1;

    localparam logic [UNIT_TICKS_W-1:0] UNIT_TICKS_RESET = 16'd562;

    // segment lengths in base units
    localparam logic [UNITS_W-1:0] UNITS_LEAD_MARK   = 5'd16;
    localparam logic [UNITS_W-1:0] UNITS_FULL_SPACE  = 5'd8;
    localparam logic [UNITS_W-1:0] UNITS_REPT_SPACE  = 5'd4;
    localparam logic [UNITS_W-1:0] UNITS_ONE_SPACE   = 5'd3;
    localparam logic [UNITS_W-1:0] UNITS_SHORT       = 5'd1;
    localparam logic [UNITS_W-1:0] UNITS_GAP         = 5'd16;

    // configuration register indexes
    localparam logic CFG_UNIT_TICKS     = 1'b0;
    localparam logic CFG_DEVICE_ADDRESS = 1'b1;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_LEAD_MARK  = 3'd1,
        PH_LEAD_SPACE = 3'd2,
        PH_BIT_MARK   = 3'd3,
        PH_BIT_SPACE  = 3'd4,
        PH_STOP_MARK  = 3'd5,
        PH_GAP        = 3'd6
    } phase_t;

    typedef struct packed {
        logic               req_type;
        logic               full_frame;
        logic [CMD_W-1:0]   command;
        logic [COUNT_W-1:0] repeat_count;
    } item_t;

    typedef struct packed {
        logic start_rejected;
        logic busy_res;
        logic ir_level;
    } result_t;

endpackage

// ===== src/ir_pulse_distance_transmitter.sv =====
// Top level of the NEC-style IR pulse-distance transmitter.
// Depends on irpd_pkg, irpd_seq, irpd_out_reg.
//
// The block takes one item per clock while the result register can take it,
// gives exactly one result item for each, in the cycle after acceptance; the
// input side stays ready whenever the result register is empty or being
// drained, so a steady stream of ticks runs at one item per cycle. A start
// item (tuser = 1) loads the command, frame kind and repeat count if the
// transmitter is idle and the count is nonzero; if it is busy the start is
// dropped and flagged. A tick item (tuser = 0) reports the carrier-enable
// level during that tick and advances the frame timer. Each base unit lasts
// unit_ticks ticks (zero acts as one). The address byte is read live while
// address bits go out, so change it only while idle, as with unit_ticks.
module ir_pulse_distance_transmitter
    import irpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port: index 0 = unit_ticks, 1 = device_address
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,  // [0] full_frame, [8:1] command,
                                                 // [16:9] repeat_count, rest zero
    input  logic                  s_axis_tuser,  // req_type
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata   // [0] ir_level, [1] busy_res,
                                                 // [2] start_rejected, rest zero
);

    logic [UNIT_TICKS_W-1:0] unit_ticks_reg;
    logic [ADDR_W-1:0]       device_address_reg;

    item_t   item;
    result_t seq_result;
    result_t out_result;
    logic    can_load;
    logic    accept;

    // hold the configuration; the user must make writes only while idle: the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg     <= UNIT_TICKS_RESET;
            device_address_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UNIT_TICKS:     unit_ticks_reg     <= cfg_wdata[UNIT_TICKS_W-1:0];
                CFG_DEVICE_ADDRESS: device_address_reg <= cfg_wdata[ADDR_W-1:0];
                default:            ;
            endcase
        end
    end

    // unpack the incoming item
    assign item.req_type     = s_axis_tuser;
    assign item.full_frame   = s_axis_tdata[0];
    assign item.command      = s_axis_tdata[8:1];
    assign item.repeat_count = s_axis_tdata[16:9];

    // take a new item whenever the result register can be refilled
    assign s_axis_tready = can_load;
    assign accept        = s_axis_tvalid && can_load;

    irpd_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (accept),
        .item           (item),
        .unit_ticks     (unit_ticks_reg),
        .device_address (device_address_reg),
        .result         (seq_result)
    );

    irpd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (seq_result),
        .can_load  (can_load),
        .valid     (m_axis_tvalid),
        .ready     (m_axis_tready),
        .data      (out_result)
    );

    // pack the result item
    assign m_axis_tdata = {5'b0, out_result.start_rejected,
                           out_result.busy_res, out_result.ir_level};

endmodule

// ===== src/irpd_seq.sv =====
// Frame sequencer of the IR pulse-distance transmitter: phase, unit and
// tick counters, bit selection. Depends on irpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module irpd_seq
    import irpd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    input  item_t                   item,
    input  logic [UNIT_TICKS_W-1:0] unit_ticks,
    input  logic [ADDR_W-1:0]       device_address,
    output result_t                 result
);

    phase_t                      phase_reg, phase_next;
    logic [BIT_IDX_W-1:0]        bit_index_reg, bit_index_next;
    logic [UNITS_W-1:0]          units_left_reg, units_left_next;
    logic [TICK_COUNT_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic [COUNT_W-1:0]          frames_left_reg, frames_left_next;
    logic                        full_flag_reg, full_flag_next;
    logic [CMD_W-1:0]            command_latch_reg, command_latch_next;
    logic                        level_reg, level_next;

    logic [CMP_W-1:0]            tick_inc;
    logic [CMP_W-1:0]            unit_len;
    logic                        unit_done;
    logic [UNITS_W-1:0]          units_dec;
    logic [BIT_IDX_W-1:0]        bit_inc;
    logic [COUNT_W-1:0]          frames_dec;
    logic [7:0]                  cur_byte;
    logic                        cur_bit;
    logic                        busy;

    assign busy     = (phase_reg != PH_IDLE);
    assign tick_inc = CMP_W'(tick_count_reg) + CMP_W'(1);
    assign unit_len = (unit_ticks == '0) ? CMP_W'(1) : CMP_W'(unit_ticks);
    assign unit_done = (tick_inc >= unit_len) || (tick_count_reg == '1);
    assign units_dec  = units_left_reg - UNITS_W'(1);
    assign bit_inc    = bit_index_reg + BIT_IDX_W'(1);
    assign frames_dec = frames_left_reg - COUNT_W'(1);

    // address, ~address, command, ~command; LSB first within each byte
    always_comb
    begin
        unique case (bit_index_reg[4:3])
            2'd0:    cur_byte = device_address;
            2'd1:    cur_byte = ~device_address;
            2'd2:    cur_byte = command_latch_reg;
            default: cur_byte = ~command_latch_reg;
        endcase
    end
    assign cur_bit = cur_byte[bit_index_reg[2:0]];

    // next state
    always_comb
    begin
        phase_next         = phase_reg;
        bit_index_next     = bit_index_reg;
        units_left_next    = units_left_reg;
        tick_count_next    = tick_count_reg;
        frames_left_next   = frames_left_reg;
        full_flag_next     = full_flag_reg;
        command_latch_next = command_latch_reg;
        level_next         = level_reg;
        if (item_valid)
        begin
            if (item.req_type == REQ_START)
            begin
                if (!busy && item.repeat_count != '0)
                begin
                    full_flag_next     = item.full_frame;
                    command_latch_next = item.command;
                    frames_left_next   = item.repeat_count;
                    bit_index_next     = '0;
                    phase_next         = PH_LEAD_MARK;
                    level_next         = 1'b1;
                    units_left_next    = UNITS_LEAD_MARK;
                    tick_count_next    = '0;
                end
            end
            else if (busy)
            begin
                if (!unit_done)
                begin
                    tick_count_next = tick_inc[TICK_COUNT_WIDTH-1:0];
                end
                else
                begin
                    tick_count_next = '0;
                    units_left_next = units_dec;
                    if (units_dec == '0)
                    begin
                        unique case (phase_reg)
                            PH_LEAD_MARK:
                            begin
                                phase_next      = PH_LEAD_SPACE;
                                level_next      = 1'b0;
                                units_left_next = full_flag_reg ? UNITS_FULL_SPACE
                                                                : UNITS_REPT_SPACE;
                            end
                            PH_LEAD_SPACE:
                            begin
                                if (full_flag_reg)
                                begin
                                    bit_index_next = '0;
                                    phase_next     = PH_BIT_MARK;
                                end
                                else
                                begin
                                    phase_next = PH_STOP_MARK;
                                end
                                level_next      = 1'b1;
                                units_left_next = UNITS_SHORT;
                            end
                            PH_BIT_MARK:
                            begin
                                phase_next      = PH_BIT_SPACE;
                                level_next      = 1'b0;
                                units_left_next = cur_bit ? UNITS_ONE_SPACE : UNITS_SHORT;
                            end
                            PH_BIT_SPACE:
                            begin
                                bit_index_next  = bit_inc;
                                phase_next      = (bit_inc == '0) ? PH_STOP_MARK
                                                                  : PH_BIT_MARK;
                                level_next      = 1'b1;
                                units_left_next = UNITS_SHORT;
                            end
                            PH_STOP_MARK:
                            begin
                                phase_next      = PH_GAP;
                                level_next      = 1'b0;
                                units_left_next = UNITS_GAP;
                            end
                            PH_GAP:
                            begin
                                frames_left_next = frames_dec;
                                if (frames_dec != '0)
                                begin
                                    phase_next      = PH_LEAD_MARK;
                                    level_next      = 1'b1;
                                    units_left_next = UNITS_LEAD_MARK;
                                end
                                else
                                begin
                                    phase_next      = PH_IDLE;
                                    level_next      = 1'b0;
                                    units_left_next = '0;
                                end
                            end
                            default:
                            begin
                                phase_next      = PH_IDLE;
                                level_next      = 1'b0;
                                units_left_next = '0;
                            end
                        endcase
                    end
                end
            end
        end
    end

    // result of the current item: a tick reports the level during it,
    // a start reports the level after it
    always_comb
    begin
        result.ir_level       = (item.req_type == REQ_START) ? level_next : level_reg;
        result.busy_res       = (phase_next != PH_IDLE);
        result.start_rejected = (item.req_type == REQ_START) && busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            bit_index_reg     <= '0;
            units_left_reg    <= '0;
            tick_count_reg    <= '0;
            frames_left_reg   <= '0;
            full_flag_reg     <= 1'b0;
            command_latch_reg <= '0;
            level_reg         <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            bit_index_reg     <= bit_index_next;
            units_left_reg    <= units_left_next;
            tick_count_reg    <= tick_count_next;
            frames_left_reg   <= frames_left_next;
            full_flag_reg     <= full_flag_next;
            command_latch_reg <= command_latch_next;
            level_reg         <= level_next;
        end
    end

    `IRPD_ASSERT(a_idle_low, !(phase_reg == PH_IDLE && level_reg), "level high while idle")
    `IRPD_ASSERT(a_busy_counts,
                 !busy || (frames_left_reg != '0 && units_left_reg != '0),
                 "busy with empty counters")
    `IRPD_ASSERT_NEXT(a_reject_holds, item_valid && item.req_type == REQ_START && busy,
                      phase_reg == $past(phase_reg) && frames_left_reg == $past(frames_left_reg),
                      "rejected start changed state")

endmodule

// ===== src/irpd_out_reg.sv =====
// Result register of the IR pulse-distance transmitter, with stream handshake.
// Depends on irpd_pkg.
module irpd_out_reg
    import irpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    output logic    can_load,
    output logic    valid,
    input  logic    ready,
    output result_t data
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign can_load   = !valid_reg || ready;
    assign valid_next = load || (valid_reg && !ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule
